@@ src/tile_sprite_pixel_writer_defines.svh @@
// Assertion macros shared by the tile sprite pixel writer RTL.
`ifndef TILE_SPRITE_PIXEL_WRITER_DEFINES_SVH
`define TILE_SPRITE_PIXEL_WRITER_DEFINES_SVH

// check prop on every clock edge outside reset
`define TSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check prop on every clock edge, reset included
`define TSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/tsp_pkg.sv @@
// Shared types, constants and address helpers of the tile sprite pixel writer.
package tsp_pkg;

  localparam int SCREEN_WIDTH  = 512;
  localparam int CELL_SIDE     = 8;
  localparam int PALETTE_COUNT = 256;

  localparam int AREA      = CELL_SIDE * CELL_SIDE;
  localparam int SIDE_W    = $clog2(CELL_SIDE);
  localparam int PIC_W     = $clog2(AREA);
  localparam int ADDR_W    = 18;
  localparam int COLOR_W   = 16;
  localparam int PIDX_W    = 12;
  localparam int PAL_DEPTH = 1 << PIDX_W;
  localparam int SEL_W     = 8;
  localparam int SEL_COUNT = 1 << SEL_W;
  localparam int NIB_W     = 4;
  localparam int BYTE_W    = 8;
  localparam int CELL_W    = 2;
  localparam int SIZE_W    = 3;
  localparam int POS_W     = 9;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 9;

  localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(1);
  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(4);

  typedef enum logic [KIND_W-1:0] {
    KIND_CELL    = 2'd0,
    KIND_PAL     = 2'd1,
    KIND_RESTART = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAL_SEL = 3'd0,
    CFG_COLUMNS = 3'd1,
    CFG_ROWS    = 3'd2,
    CFG_ORIG_X  = 3'd3,
    CFG_ORIG_Y  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [SEL_W-1:0]  palette_select;
    logic [SIZE_W-1:0] sprite_columns;
    logic [SIZE_W-1:0] sprite_rows;
    logic [POS_W-1:0]  origin_x;
    logic [POS_W-1:0]  origin_y;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    palette_select: SEL_W'(0),
    sprite_columns: SIZE_W'(1),
    sprite_rows:    SIZE_W'(1),
    origin_x:       POS_W'(128),
    origin_y:       POS_W'(64)
  };

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PIDX_W-1:0] pidx;
    logic              last;
  } slot_t;

  typedef struct packed {
    logic [1:0]      live;
    slot_t [1:0]     slot;
  } job_t;

  typedef logic [SEL_COUNT-1:0][SEL_W-1:0] pal_tbl_t;

  function automatic pal_tbl_t build_pal_mod();
    pal_tbl_t t;
    for (int i = 0; i < SEL_COUNT; i++) begin
      t[i] = SEL_W'(i % PALETTE_COUNT);
    end
    return t;
  endfunction

  localparam pal_tbl_t PAL_MOD = build_pal_mod();

  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v < SIZE_MIN) r = SIZE_MIN;
    if (v > SIZE_MAX) r = SIZE_MAX;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] screen_addr(cfg_t cfg, logic [CELL_W-1:0] col,
                                                    logic [CELL_W-1:0] row,
                                                    logic [SIDE_W:0] px, logic [SIDE_W:0] py);
    logic [ADDR_W-1:0] row_s;
    logic [ADDR_W-1:0] col_s;
    row_s = ADDR_W'(cfg.origin_y) + ADDR_W'(ADDR_W'(CELL_SIDE) * ADDR_W'(row)) + ADDR_W'(py);
    col_s = ADDR_W'(cfg.origin_x) + ADDR_W'(ADDR_W'(CELL_SIDE) * ADDR_W'(col)) + ADDR_W'(px);
    return ADDR_W'(row_s * ADDR_W'(SCREEN_WIDTH)) + col_s;
  endfunction

endpackage

@@ src/tile_sprite_pixel_writer.sv @@
// Top level of the tile sprite pixel writer: configuration, read issue and result stages.
// A cell byte is taken and then issues one palette read per visible pixel through the
// palette memory's single read port; a byte with both nibbles opaque stalls the next request
// until its second read issues; reads wait while the result stages are full. Palette writes,
// restarts and fully transparent bytes issue no read. A pixel passes the read stage, then
// the result stage. After reset a pass zeroes the palette memory, during which no request is
// taken; configuration writes are taken at all times and should only be made while idle.
`include "tile_sprite_pixel_writer_defines.svh"

module tile_sprite_pixel_writer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tsp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tsp_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tsp_pkg::KIND_W-1:0]     kind_i,
  input  logic [tsp_pkg::BYTE_W-1:0]     cell_byte_i,
  input  logic [tsp_pkg::PIDX_W-1:0]     palette_index_i,
  input  logic [tsp_pkg::COLOR_W-1:0]    palette_color_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tsp_pkg::ADDR_W-1:0]     pixel_address_o,
  output logic [tsp_pkg::COLOR_W-1:0]    pixel_color_o,
  output logic                           last_of_byte_o
);

  tsp_pkg::cfg_t cfg_q, cfg_d;
  tsp_pkg::job_t job;
  tsp_pkg::slot_t [1:0] slot_q, slot_d;
  tsp_pkg::slot_t sel_slot;
  logic [1:0] pend_q, pend_d;

  logic in_acc, byte_en, restart, pal_wr;
  logic has_pend, sel, issue, job_free;
  logic out_free, rd_free, rd_move;
  logic clr_busy;
  logic [tsp_pkg::COLOR_W-1:0] rd_data;

  logic                         rd_valid_q, rd_valid_d;
  logic [tsp_pkg::ADDR_W-1:0]   rd_addr_q, rd_addr_d;
  logic                         rd_last_q, rd_last_d;
  logic                         out_valid_q, out_valid_d;
  logic [tsp_pkg::ADDR_W-1:0]   out_addr_q, out_addr_d;
  logic [tsp_pkg::COLOR_W-1:0]  out_color_q, out_color_d;
  logic                         out_last_q, out_last_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (tsp_pkg::cfg_idx_e'(cfg_index_i))
        tsp_pkg::CFG_PAL_SEL: cfg_d.palette_select = cfg_data_i[tsp_pkg::SEL_W-1:0];
        tsp_pkg::CFG_COLUMNS: cfg_d.sprite_columns = cfg_data_i[tsp_pkg::SIZE_W-1:0];
        tsp_pkg::CFG_ROWS:    cfg_d.sprite_rows    = cfg_data_i[tsp_pkg::SIZE_W-1:0];
        tsp_pkg::CFG_ORIG_X:  cfg_d.origin_x       = cfg_data_i[tsp_pkg::POS_W-1:0];
        tsp_pkg::CFG_ORIG_Y:  cfg_d.origin_y       = cfg_data_i[tsp_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  // result stages
  assign out_free = !out_valid_q || !out_stall_i;
  assign rd_move  = rd_valid_q && out_free;
  assign rd_free  = !rd_valid_q || out_free;

  // read issue from the pending job
  assign has_pend = |pend_q;
  assign sel      = !pend_q[0];
  assign sel_slot = slot_q[sel];
  assign issue    = has_pend && rd_free;
  assign job_free = !has_pend || (issue && (pend_q != 2'b11));

  assign in_stall_o = clr_busy || !job_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign byte_en    = in_acc && (tsp_pkg::kind_e'(kind_i) == tsp_pkg::KIND_CELL);
  assign pal_wr     = in_acc && (tsp_pkg::kind_e'(kind_i) == tsp_pkg::KIND_PAL);
  assign restart    = in_acc && (tsp_pkg::kind_e'(kind_i) == tsp_pkg::KIND_RESTART);

  always_comb begin
    pend_d = pend_q;
    slot_d = slot_q;
    if (issue) begin
      pend_d[sel] = 1'b0;
    end
    if (byte_en) begin
      pend_d = job.live;
      slot_d = job.slot;
    end
  end

  always_comb begin
    rd_valid_d  = rd_valid_q;
    rd_addr_d   = rd_addr_q;
    rd_last_d   = rd_last_q;
    out_valid_d = out_valid_q;
    out_addr_d  = out_addr_q;
    out_color_d = out_color_q;
    out_last_d  = out_last_q;
    if (rd_move) begin
      out_valid_d = 1'b1;
      out_addr_d  = rd_addr_q;
      out_color_d = rd_data;
      out_last_d  = rd_last_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (issue) begin
      rd_valid_d = 1'b1;
      rd_addr_d  = sel_slot.addr;
      rd_last_d  = sel_slot.last;
    end else if (rd_move) begin
      rd_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= tsp_pkg::CFG_RESET;
      pend_q      <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      pend_q      <= pend_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q      <= slot_d;
    rd_addr_q   <= rd_addr_d;
    rd_last_q   <= rd_last_d;
    out_addr_q  <= out_addr_d;
    out_color_q <= out_color_d;
    out_last_q  <= out_last_d;
  end

  tsp_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .byte_en_i   (byte_en),
    .restart_i   (restart),
    .cell_byte_i (cell_byte_i),
    .job_o       (job)
  );

  tsp_palette_ram u_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (pal_wr),
    .wr_addr_i  (palette_index_i),
    .wr_data_i  (palette_color_i),
    .rd_en_i    (issue),
    .rd_addr_i  (sel_slot.pidx),
    .rd_data_o  (rd_data),
    .clr_busy_o (clr_busy)
  );

  assign out_valid_o     = out_valid_q;
  assign pixel_address_o = out_addr_q;
  assign pixel_color_o   = out_color_q;
  assign last_of_byte_o  = out_last_q;

  `TSP_ASSERT(a_rd_hold, rd_valid_q && !out_free |=> rd_valid_q && $stable(rd_addr_q), "read stage lost a stalled pixel")
  `TSP_ASSERT(a_clr_once, !clr_busy |=> !clr_busy, "palette clearing pass restarted")
  `TSP_ASSERT(a_no_overrun, byte_en |-> (pend_q == 2'b00) || (issue && (pend_q != 2'b11)), "cell byte taken over unissued pixels")
  `TSP_ASSERT_ALWAYS(a_clr_quiet, clr_busy |-> !in_acc && !issue, "palette accessed during clearing pass")

endmodule

@@ src/tsp_palette_ram.sv @@
// Palette memory with a zeroing sweep after reset and a registered read port.
module tsp_palette_ram (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [tsp_pkg::PIDX_W-1:0]   wr_addr_i,
  input  logic [tsp_pkg::COLOR_W-1:0]  wr_data_i,
  input  logic                         rd_en_i,
  input  logic [tsp_pkg::PIDX_W-1:0]   rd_addr_i,
  output logic [tsp_pkg::COLOR_W-1:0]  rd_data_o,
  output logic                         clr_busy_o
);

  logic [tsp_pkg::COLOR_W-1:0] mem [tsp_pkg::PAL_DEPTH];
  logic [tsp_pkg::COLOR_W-1:0] rd_data_q;
  logic [tsp_pkg::PIDX_W-1:0]  clr_cnt_q, clr_cnt_d;
  logic                        clr_busy_q, clr_busy_d;
  logic                        we;
  logic [tsp_pkg::PIDX_W-1:0]  waddr;
  logic [tsp_pkg::COLOR_W-1:0] wdata;

  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + tsp_pkg::PIDX_W'(1);
      if (&clr_cnt_q) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  assign we    = clr_busy_q | wr_en_i;
  assign waddr = clr_busy_q ? clr_cnt_q : wr_addr_i;
  assign wdata = clr_busy_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = clr_busy_q;

endmodule

@@ src/tsp_walk.sv @@
// Sprite walk counters and the pixel jobs that one cell byte produces.
module tsp_walk (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tsp_pkg::cfg_t               cfg_i,
  input  logic                        byte_en_i,
  input  logic                        restart_i,
  input  logic [tsp_pkg::BYTE_W-1:0]  cell_byte_i,
  output tsp_pkg::job_t               job_o
);

  localparam logic [tsp_pkg::SIDE_W:0] SIDE_E = (tsp_pkg::SIDE_W + 1)'(tsp_pkg::CELL_SIDE);
  localparam logic [tsp_pkg::SIDE_W:0] ONE_E  = (tsp_pkg::SIDE_W + 1)'(1);
  localparam logic [tsp_pkg::PIC_W:0]  AREA_E = (tsp_pkg::PIC_W + 1)'(tsp_pkg::AREA);

  logic [tsp_pkg::CELL_W-1:0] col_q, col_d, row_q, row_d;
  logic [tsp_pkg::PIC_W-1:0]  pic_q, pic_d;
  logic [tsp_pkg::SIDE_W-1:0] px_q, px_d, py_q, py_d;

  logic [tsp_pkg::SIDE_W:0]   px0, py0, px1, py1, px2, py2;
  logic                       wrap1, wrap2;
  logic [tsp_pkg::PIC_W:0]    pic1, pic2;
  logic [tsp_pkg::NIB_W-1:0]  nib_hi, nib_lo;
  logic [tsp_pkg::SEL_W-1:0]  pal_base;
  logic                       live0, live1;
  logic [tsp_pkg::SIZE_W-1:0] cols, rows, col3, row3;

  always_comb begin
    px0    = {1'b0, px_q};
    py0    = {1'b0, py_q};
    wrap1  = (px0 + ONE_E) == SIDE_E;
    px1    = wrap1 ? '0 : px0 + ONE_E;
    py1    = wrap1 ? py0 + ONE_E : py0;
    pic1   = {1'b0, pic_q} + (tsp_pkg::PIC_W + 1)'(1);
    pic2   = {1'b0, pic_q} + (tsp_pkg::PIC_W + 1)'(2);
    nib_hi = cell_byte_i[tsp_pkg::BYTE_W-1:tsp_pkg::NIB_W];
    nib_lo = cell_byte_i[tsp_pkg::NIB_W-1:0];
    live0  = nib_hi != '0;
    live1  = (nib_lo != '0) && (pic1 < AREA_E);
    pal_base = tsp_pkg::PAL_MOD[cfg_i.palette_select];

    job_o.live         = {live1, live0};
    job_o.slot[0].addr = tsp_pkg::screen_addr(cfg_i, col_q, row_q, px0, py0);
    job_o.slot[0].pidx = {pal_base, nib_hi};
    job_o.slot[0].last = !live1;
    job_o.slot[1].addr = tsp_pkg::screen_addr(cfg_i, col_q, row_q, px1, py1);
    job_o.slot[1].pidx = {pal_base, nib_lo};
    job_o.slot[1].last = 1'b1;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    pic_d = pic_q;
    px_d  = px_q;
    py_d  = py_q;
    cols  = tsp_pkg::clamp_size(cfg_i.sprite_columns);
    rows  = tsp_pkg::clamp_size(cfg_i.sprite_rows);
    col3  = {1'b0, col_q} + tsp_pkg::SIZE_W'(1);
    row3  = {1'b0, row_q};
    px2   = px0 + (tsp_pkg::SIDE_W + 1)'(2);
    wrap2 = px2 >= SIDE_E;
    py2   = wrap2 ? py0 + ONE_E : py0;
    if (wrap2) begin
      px2 = px2 - SIDE_E;
    end
    if (restart_i) begin
      col_d = '0;
      row_d = '0;
      pic_d = '0;
      px_d  = '0;
      py_d  = '0;
    end else if (byte_en_i) begin
      if (pic2 >= AREA_E) begin
        pic_d = '0;
        px_d  = '0;
        py_d  = '0;
        if (col3 >= cols) begin
          col3 = '0;
          row3 = row3 + tsp_pkg::SIZE_W'(1);
        end
        if (row3 >= rows) begin
          row3 = '0;
        end
        col_d = col3[tsp_pkg::CELL_W-1:0];
        row_d = row3[tsp_pkg::CELL_W-1:0];
      end else begin
        pic_d = pic2[tsp_pkg::PIC_W-1:0];
        px_d  = px2[tsp_pkg::SIDE_W-1:0];
        py_d  = py2[tsp_pkg::SIDE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      pic_q <= '0;
      px_q  <= '0;
      py_q  <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      pic_q <= pic_d;
      px_q  <= px_d;
      py_q  <= py_d;
    end
  end

endmodule
